FILE: rtl/core/uer_pkg.sv
// Shared types and constants for the ultrasonic echo ranger.
`default_nettype none
package uer_pkg;

   typedef enum logic [1:0] {
      MODE_IDLE      = 2'd0,
      MODE_WAIT_RISE = 2'd1,
      MODE_WAIT_FALL = 2'd2
   } mode_type;

   localparam logic [1:0] STATUS_NONE    = 2'd0;
   localparam logic [1:0] STATUS_VALID   = 2'd1;
   localparam logic [1:0] STATUS_TIMEOUT = 2'd2;

   localparam int unsigned CSR_INDEX_WIDTH = 3;
   localparam logic [2:0] CSR_TICKS_PER_US = 3'd0;
   localparam logic [2:0] CSR_MIN_ECHO_US  = 3'd1;
   localparam logic [2:0] CSR_MAX_ECHO_US  = 3'd2;
   localparam logic [2:0] CSR_HOLDOFF_US   = 3'd3;
   localparam logic [2:0] CSR_TIMEOUT_US   = 3'd4;
   localparam logic [2:0] CSR_PULSE_US     = 3'd5;

   localparam logic [7:0]  RST_TICKS_PER_US = 8'd150;
   localparam logic [15:0] RST_MIN_ECHO_US  = 16'd116;
   localparam logic [15:0] RST_MAX_ECHO_US  = 16'd23300;
   localparam logic [15:0] RST_HOLDOFF_US   = 16'd60000;
   localparam logic [15:0] RST_TIMEOUT_US   = 16'd40000;
   localparam logic [7:0]  RST_PULSE_US     = 8'd10;

   localparam logic [7:0]  DEFAULT_TPU = 8'd150;
   localparam logic [16:0] SCALE_MUL   = 17'd112394;
   localparam int unsigned SCALE_SHIFT = 16;

   typedef struct packed {
      logic [7:0]  ticks_per_us;
      logic [15:0] min_echo_us;
      logic [15:0] max_echo_us;
      logic [15:0] holdoff_us;
      logic [15:0] timeout_us;
      logic [7:0]  pulse_us;
   } cfg_type;

   typedef struct packed {
      logic        trigger_level;
      logic [15:0] distance_centi_cm;
      logic [1:0]  result_status;
      logic        result_updated;
      logic        busy_res;
   } result_type;

endpackage
`default_nettype wire

FILE: rtl/core/uer_scale.sv
// Converts an echo width in microseconds to hundredths of a centimeter.
`default_nettype none
module uer_scale #(
   parameter int unsigned US_COUNT_WIDTH = 16
) (
   input  wire logic [US_COUNT_WIDTH-1:0] width_us,
   output logic [15:0]                    distance_centi_cm
);

   localparam int unsigned PROD_WIDTH = US_COUNT_WIDTH + 17;

   logic [PROD_WIDTH-1:0]     product;
   logic [US_COUNT_WIDTH:0]   scaled;

   always_comb begin
      product = PROD_WIDTH'(width_us) * PROD_WIDTH'(uer_pkg::SCALE_MUL);
      scaled  = product[PROD_WIDTH-1:uer_pkg::SCALE_SHIFT];
      if (|scaled[US_COUNT_WIDTH:16]) begin
         distance_centi_cm = 16'hFFFF;
      end else begin
         distance_centi_cm = scaled[15:0];
      end
   end

endmodule
`default_nettype wire

FILE: rtl/core/uer_ctrl.sv
// Measurement state machine, microsecond prescaler and counters.
`default_nettype none
module uer_ctrl #(
   parameter int unsigned US_COUNT_WIDTH = 16
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               step,
   input  wire logic               echo_level,
   input  wire logic               start_request,
   input  wire uer_pkg::cfg_type   cfg,
   output uer_pkg::result_type     result
);

   localparam int unsigned W = US_COUNT_WIDTH;

   uer_pkg::mode_type mode_ff, mode_in;
   logic [7:0]   prescale_ff, prescale_in;
   logic [W-1:0] since_ff, since_in;
   logic [W-1:0] width_ff, width_in;
   logic         trig_before_ff, trig_before_in;
   logic [7:0]   pulse_left_ff, pulse_left_in;
   logic         last_echo_ff;
   logic [15:0]  held_dist_ff, held_dist_in;
   logic [1:0]   held_status_ff, held_status_in;

   logic [7:0]   tpu;
   logic         us_tick;
   logic [W-1:0] width_step;
   logic         rise;
   logic         fall;
   logic [15:0]  scaled_dist;

   uer_scale #(.US_COUNT_WIDTH(W)) u_scale (
      .width_us          (width_step),
      .distance_centi_cm (scaled_dist)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff        <= uer_pkg::MODE_IDLE;
         prescale_ff    <= '0;
         since_ff       <= '0;
         width_ff       <= '0;
         trig_before_ff <= 1'b0;
         pulse_left_ff  <= '0;
         last_echo_ff   <= 1'b0;
         held_dist_ff   <= '0;
         held_status_ff <= uer_pkg::STATUS_NONE;
      end else if (step) begin
         mode_ff        <= mode_in;
         prescale_ff    <= prescale_in;
         since_ff       <= since_in;
         width_ff       <= width_in;
         trig_before_ff <= trig_before_in;
         pulse_left_ff  <= pulse_left_in;
         last_echo_ff   <= echo_level;
         held_dist_ff   <= held_dist_in;
         held_status_ff <= held_status_in;
      end
   end

   // The echo width used at a falling edge includes this tick's increment.
   always_comb begin
      tpu        = (cfg.ticks_per_us == 8'd0) ? uer_pkg::DEFAULT_TPU : cfg.ticks_per_us;
      us_tick    = ({1'b0, prescale_ff} + 9'd1) >= {1'b0, tpu};
      width_step = width_ff;
      if (us_tick && mode_ff == uer_pkg::MODE_WAIT_FALL && width_ff != '1) begin
         width_step = width_ff + W'(1);
      end
   end

   always_comb begin
      prescale_in = us_tick ? 8'd0 : prescale_ff + 8'd1;
      since_in    = since_ff;
      width_in    = width_step;
      pulse_left_in = pulse_left_ff;
      if (us_tick) begin
         if (since_ff != '1) begin
            since_in = since_ff + W'(1);
         end
         if (pulse_left_ff != 8'd0) begin
            pulse_left_in = pulse_left_ff - 8'd1;
         end
      end

      mode_in        = mode_ff;
      trig_before_in = trig_before_ff;
      held_dist_in   = held_dist_ff;
      held_status_in = held_status_ff;

      rise = echo_level && !last_echo_ff;
      fall = !echo_level && last_echo_ff && (mode_ff == uer_pkg::MODE_WAIT_FALL);

      if (rise) begin
         width_in = '0;
         mode_in  = uer_pkg::MODE_WAIT_FALL;
      end else if (fall) begin
         if (width_step >= W'(cfg.min_echo_us) && width_step <= W'(cfg.max_echo_us)) begin
            held_dist_in   = scaled_dist;
            held_status_in = uer_pkg::STATUS_VALID;
         end
         mode_in = uer_pkg::MODE_IDLE;
      end

      if (start_request && mode_in == uer_pkg::MODE_IDLE &&
          (!trig_before_ff || since_in >= W'(cfg.holdoff_us))) begin
         mode_in        = uer_pkg::MODE_WAIT_RISE;
         since_in       = '0;
         trig_before_in = 1'b1;
         pulse_left_in  = cfg.pulse_us;
      end

      case (mode_in)
         uer_pkg::MODE_IDLE: begin
         end
         default: begin
            if (since_in > W'(cfg.timeout_us)) begin
               mode_in        = uer_pkg::MODE_IDLE;
               held_status_in = uer_pkg::STATUS_TIMEOUT;
            end
         end
      endcase

      result.trigger_level     = (pulse_left_in != 8'd0);
      result.distance_centi_cm = held_dist_in;
      result.result_status     = held_status_in;
      result.result_updated    = (held_dist_in != held_dist_ff) ||
                                 (held_status_in != held_status_ff);
      result.busy_res          = (mode_in != uer_pkg::MODE_IDLE);
   end

endmodule
`default_nettype wire

FILE: rtl/core/ultrasonic_echo_ranger.sv
// Top level of the ultrasonic echo ranger: handshakes, registers and result stage.
//
//   channel  direction  handshake            payload
//   req_     in         req_valid/req_ready  echo_level, start_request
//   rsp_     out        rsp_valid/rsp_ready  trigger, distance, status, updated, busy
//   csr_     in         csr_valid/csr_ready  csr_index, csr_data
//
// One transaction per cycle sustained while rsp_ready stays high; a transaction's result is
// presented after passing through one input register and then one result register.
// Reset is synchronous and clears all control state and loads register defaults.
// A stalled result holds the result register; the input register still takes one
// more transaction before req_ready drops. csr_ready is always high.
`default_nettype none
module ultrasonic_echo_ranger #(
   parameter int unsigned US_COUNT_WIDTH = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic        req_echo_level,
   input  wire logic        req_start_request,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic             rsp_trigger_level,
   output logic [15:0]      rsp_distance_centi_cm,
   output logic [1:0]       rsp_result_status,
   output logic             rsp_result_updated,
   output logic             rsp_busy_res,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [uer_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  wire logic [15:0] csr_data
);

   uer_pkg::cfg_type    cfg_ff;
   uer_pkg::result_type result;
   uer_pkg::result_type rsp_ff;

   logic in_valid_ff, in_valid_in;
   logic in_echo_ff;
   logic in_start_ff;
   logic rsp_valid_ff, rsp_valid_in;
   logic advance;

   assign csr_ready = 1'b1;
   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.ticks_per_us <= uer_pkg::RST_TICKS_PER_US;
         cfg_ff.min_echo_us  <= uer_pkg::RST_MIN_ECHO_US;
         cfg_ff.max_echo_us  <= uer_pkg::RST_MAX_ECHO_US;
         cfg_ff.holdoff_us   <= uer_pkg::RST_HOLDOFF_US;
         cfg_ff.timeout_us   <= uer_pkg::RST_TIMEOUT_US;
         cfg_ff.pulse_us     <= uer_pkg::RST_PULSE_US;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            uer_pkg::CSR_TICKS_PER_US: cfg_ff.ticks_per_us <= csr_data[7:0];
            uer_pkg::CSR_MIN_ECHO_US:  cfg_ff.min_echo_us  <= csr_data;
            uer_pkg::CSR_MAX_ECHO_US:  cfg_ff.max_echo_us  <= csr_data;
            uer_pkg::CSR_HOLDOFF_US:   cfg_ff.holdoff_us   <= csr_data;
            uer_pkg::CSR_TIMEOUT_US:   cfg_ff.timeout_us   <= csr_data;
            uer_pkg::CSR_PULSE_US:     cfg_ff.pulse_us     <= csr_data[7:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_echo_ff  <= req_echo_level;
         in_start_ff <= req_start_request;
      end
      if (advance) begin
         rsp_ff <= result;
      end
   end

   uer_ctrl #(.US_COUNT_WIDTH(US_COUNT_WIDTH)) u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .step          (advance),
      .echo_level    (in_echo_ff),
      .start_request (in_start_ff),
      .cfg           (cfg_ff),
      .result        (result)
   );

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_trigger_level     = rsp_ff.trigger_level;
   assign rsp_distance_centi_cm = rsp_ff.distance_centi_cm;
   assign rsp_result_status     = rsp_ff.result_status;
   assign rsp_result_updated    = rsp_ff.result_updated;
   assign rsp_busy_res          = rsp_ff.busy_res;

endmodule
`default_nettype wire

FILE: rtl/core/uer_checker.sv
// Port-level checks for the ultrasonic echo ranger and their bind.
`default_nettype none
module uer_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_ready,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [15:0] rsp_distance_centi_cm,
   input wire logic [1:0]  rsp_result_status
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_distance_centi_cm) &&
      $stable(rsp_result_status))
      else $error("result changed while stalled");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_result_status != 2'd3)
      else $error("undefined result status");

   a_none_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_result_status == uer_pkg::STATUS_NONE |->
      rsp_distance_centi_cm == 16'd0)
      else $error("distance present before any valid measurement");

   a_ready_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input stalled while result stage is empty");

endmodule

bind ultrasonic_echo_ranger uer_checker u_uer_checker (
   .clock                 (clock),
   .reset                 (reset),
   .req_ready             (req_ready),
   .rsp_valid             (rsp_valid),
   .rsp_ready             (rsp_ready),
   .rsp_distance_centi_cm (rsp_distance_centi_cm),
   .rsp_result_status     (rsp_result_status)
);
`default_nettype wire
